[rtl/heq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package heq_pkg;

    localparam int LEVELS    = 256;
    localparam int LEVEL_W   = 8;
    localparam int SUM_W     = 21;
    localparam int NUM_W     = SUM_W + LEVEL_W;
    localparam int CFG_W     = 11;
    localparam int DIV_W     = 2 * CFG_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic signed [10:0] K_YR = 11'sd66;
    localparam logic signed [10:0] K_YG = 11'sd129;
    localparam logic signed [10:0] K_YB = 11'sd25;
    localparam logic signed [10:0] K_UR = -11'sd38;
    localparam logic signed [10:0] K_UG = -11'sd74;
    localparam logic signed [10:0] K_UB = 11'sd112;
    localparam logic signed [10:0] K_VR = 11'sd122;
    localparam logic signed [10:0] K_VG = -11'sd94;
    localparam logic signed [10:0] K_VB = -11'sd18;
    localparam logic signed [10:0] K_RY = 11'sd298;
    localparam logic signed [10:0] K_RU = 11'sd0;
    localparam logic signed [10:0] K_RV = 11'sd409;
    localparam logic signed [10:0] K_GY = 11'sd298;
    localparam logic signed [10:0] K_GU = -11'sd100;
    localparam logic signed [10:0] K_GV = -11'sd208;
    localparam logic signed [10:0] K_BY = 11'sd298;
    localparam logic signed [10:0] K_BU = 11'sd516;
    localparam logic signed [10:0] K_BV = 11'sd0;

    localparam logic signed [9:0] OFS_Y  = 10'sd16;
    localparam logic signed [9:0] OFS_C  = 10'sd128;
    localparam logic signed [9:0] OFS_0  = 10'sd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YUV,
        ST_RD,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_RGB
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } t_div_rsp;

    // Weighted sum of three terms, rounded, floored by 256, offset and clipped to 8 bits.
    function automatic logic [7:0] lin3(
        input logic signed [10:0] k0,
        input logic signed [10:0] k1,
        input logic signed [10:0] k2,
        input logic signed [9:0]  a0,
        input logic signed [9:0]  a1,
        input logic signed [9:0]  a2,
        input logic signed [9:0]  ofs
    );
        logic signed [19:0] s;
        logic [7:0]         res;
        s = 20'(k0) * 20'(a0) + 20'(k1) * 20'(a1) + 20'(k2) * 20'(a2) + 20'sd128;
        s = (s >>> 8) + 20'(ofs);
        if (s < 20'sd0) begin
            res = 8'd0;
        end else if (s > 20'sd255) begin
            res = 8'd255;
        end else begin
            res = s[7:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/heq_cdf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module heq_cdf_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [heq_pkg::LEVEL_W-1:0]   i_waddr,
    input  wire logic [heq_pkg::SUM_W-1:0]     i_wdata,
    input  wire logic                          i_re,
    input  wire logic [heq_pkg::LEVEL_W-1:0]   i_raddr,
    output logic      [heq_pkg::SUM_W-1:0]     o_rdata
);

    logic [heq_pkg::SUM_W-1:0] r_mem [heq_pkg::LEVELS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/heq_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle; caller guarantees quotient < 256.
module heq_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire heq_pkg::t_div_req i_req,
    output heq_pkg::t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(heq_pkg::LEVEL_W + 1);

    logic                          r_busy, n_busy;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [heq_pkg::DIV_W-1:0]     r_rem, n_rem;
    logic [heq_pkg::LEVEL_W-1:0]   r_low, n_low;
    logic [heq_pkg::LEVEL_W-1:0]   r_quo, n_quo;
    logic [heq_pkg::DIV_W-1:0]     r_div, n_div;
    logic                          r_done, n_done;
    logic [heq_pkg::DIV_W:0]       w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_low   = r_low;
        n_quo   = r_quo;
        n_div   = r_div;
        n_done  = 1'b0;
        w_trial = {r_rem, r_low[heq_pkg::LEVEL_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(heq_pkg::LEVEL_W);
            n_rem  = heq_pkg::DIV_W'(i_req.dividend[heq_pkg::NUM_W-1:heq_pkg::LEVEL_W]);
            n_low  = i_req.dividend[heq_pkg::LEVEL_W-1:0];
            n_div  = i_req.divisor;
            n_quo  = '0;
        end else if (r_busy) begin
            // shift in next dividend bit, subtract when it fits
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = heq_pkg::DIV_W'(w_trial - {1'b0, r_div});
                n_quo = {r_quo[heq_pkg::LEVEL_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[heq_pkg::DIV_W-1:0];
                n_quo = {r_quo[heq_pkg::LEVEL_W-2:0], 1'b0};
            end
            n_low = {r_low[heq_pkg::LEVEL_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_low <= n_low;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

[rtl/rgb_luma_histogram_equalizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Handshake                  | Payload
// ----------+----------------------------+--------------------------------------------
// input     | i_in_valid / o_in_ready    | i_operation, i_bin_count, i_red/green/blue_in
// output    | o_out_valid / i_out_ready  | o_red_out, o_green_out, o_blue_out
// config    | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// A bin item is absorbed on acceptance: add to the running sum and write the CDF RAM.
// A pixel item runs from acceptance to the next ready through: acceptance, color
// conversion, registered RAM read, scale multiply, range check, the divide (8 quotient
// bits, then the done flag) and the output step. A zero cdf, a tiny frame or a saturated
// quotient skips the divide.
// Reset (synchronous, active low) clears the load position, sum, sequencer and output valid.
// The finished pixel waits in the output register; the next item enters meanwhile,
// and a pixel stalls in its last step only while the output register is still full.
module rgb_luma_histogram_equalizer #(
    parameter int LINE_MAX        = 1920,
    parameter int FRAME_LINES_MAX = 1080
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [heq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [heq_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_operation,
    input  wire logic [18:0]                     i_bin_count,
    input  wire logic [7:0]                      i_red_in,
    input  wire logic [7:0]                      i_green_in,
    input  wire logic [7:0]                      i_blue_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [7:0]                      o_red_out,
    output logic      [7:0]                      o_green_out,
    output logic      [7:0]                      o_blue_out
);

    localparam int SUM_W = heq_pkg::SUM_W;
    localparam int LW    = heq_pkg::LEVEL_W;
    localparam int CW    = heq_pkg::CFG_W;
    localparam int DW    = heq_pkg::DIV_W;
    localparam logic [CW-1:0] W_MAX = CW'(LINE_MAX);
    localparam logic [CW-1:0] H_MAX = CW'(FRAME_LINES_MAX);

    heq_pkg::t_state r_state, n_state;

    logic [CW-1:0]           r_width, r_height;
    logic [SUM_W-1:0]        r_sum;
    logic [LW-1:0]           r_ptr;
    logic [7:0]              r_red, r_green, r_blue;
    logic [7:0]              r_y, r_u, r_v, r_luma;
    logic [2*CW-1:0]         r_area;
    logic [heq_pkg::NUM_W-1:0] r_num;
    logic                    r_czero;
    logic                    r_out_valid;
    logic [7:0]              r_ro, r_go, r_bo;

    logic                    w_in_acc, w_bin_acc, w_pix_acc;
    logic [SUM_W:0]          w_sum_raw;
    logic [SUM_W-1:0]        w_sum_sat;
    logic [CW-1:0]           w_w, w_h;
    logic [SUM_W-1:0]        w_rdata;
    logic [DW-1:0]           w_divisor;
    logic                    w_small;
    logic                    w_over;
    logic                    w_load_out;
    heq_pkg::t_div_req       w_req;
    heq_pkg::t_div_rsp       w_rsp;

    assign o_in_ready = (r_state == heq_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_bin_acc  = w_in_acc && !i_operation;
    assign w_pix_acc  = w_in_acc && i_operation;

    // saturating running sum
    assign w_sum_raw = {1'b0, r_sum} + (SUM_W+1)'(i_bin_count);
    assign w_sum_sat = w_sum_raw[SUM_W] ? heq_pkg::SUM_MAX : w_sum_raw[SUM_W-1:0];

    assign w_w = (r_width  > W_MAX) ? W_MAX : r_width;
    assign w_h = (r_height > H_MAX) ? H_MAX : r_height;

    // area of up to 2047*2047 needs the full 22-bit divisor
    assign w_small   = (r_area <= (2*CW)'(1));
    assign w_divisor = DW'(r_area - (2*CW)'(1));
    assign w_over    = ({1'b0, r_num} >= {w_divisor, {LW{1'b0}}});

    assign w_req.start    = (r_state == heq_pkg::ST_CHK) && !r_czero && !w_small && !w_over;
    assign w_req.dividend = r_num;
    assign w_req.divisor  = w_divisor;

    assign w_load_out = (r_state == heq_pkg::ST_RGB) && (!r_out_valid || i_out_ready);

    heq_cdf_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_bin_acc),
        .i_waddr (r_ptr),
        .i_wdata (w_sum_sat),
        .i_re    (r_state == heq_pkg::ST_RD),
        .i_raddr (r_y),
        .o_rdata (w_rdata)
    );

    heq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            heq_pkg::ST_IDLE: if (w_pix_acc) n_state = heq_pkg::ST_YUV;
            heq_pkg::ST_YUV:  n_state = heq_pkg::ST_RD;
            heq_pkg::ST_RD:   n_state = heq_pkg::ST_MUL;
            heq_pkg::ST_MUL:  n_state = heq_pkg::ST_CHK;
            heq_pkg::ST_CHK:  n_state = w_req.start ? heq_pkg::ST_DIV : heq_pkg::ST_RGB;
            heq_pkg::ST_DIV:  if (w_rsp.done) n_state = heq_pkg::ST_RGB;
            heq_pkg::ST_RGB:  if (w_load_out) n_state = heq_pkg::ST_IDLE;
            default:          n_state = heq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= heq_pkg::ST_IDLE;
            r_width     <= CW'(1920);
            r_height    <= CW'(1080);
            r_sum       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    heq_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    heq_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_bin_acc) begin
                // wrap and clear after the last level
                if (r_ptr == LW'(heq_pkg::LEVELS - 1)) begin
                    r_ptr <= '0;
                    r_sum <= '0;
                end else begin
                    r_ptr <= r_ptr + LW'(1);
                    r_sum <= w_sum_sat;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_pix_acc) begin
            r_red   <= i_red_in;
            r_green <= i_green_in;
            r_blue  <= i_blue_in;
        end
        if (r_state == heq_pkg::ST_YUV) begin
            r_y <= heq_pkg::lin3(heq_pkg::K_YR, heq_pkg::K_YG, heq_pkg::K_YB,
                {2'b00, r_red}, {2'b00, r_green}, {2'b00, r_blue}, heq_pkg::OFS_Y);
            r_u <= heq_pkg::lin3(heq_pkg::K_UR, heq_pkg::K_UG, heq_pkg::K_UB,
                {2'b00, r_red}, {2'b00, r_green}, {2'b00, r_blue}, heq_pkg::OFS_C);
            r_v <= heq_pkg::lin3(heq_pkg::K_VR, heq_pkg::K_VG, heq_pkg::K_VB,
                {2'b00, r_red}, {2'b00, r_green}, {2'b00, r_blue}, heq_pkg::OFS_C);
            r_area <= w_w * w_h;
        end
        if (r_state == heq_pkg::ST_MUL) begin
            r_czero <= (w_rdata == '0);
            r_num   <= heq_pkg::NUM_W'(w_rdata - SUM_W'(1))
                       * heq_pkg::NUM_W'(heq_pkg::LEVELS - 1);
        end
        if (r_state == heq_pkg::ST_CHK) begin
            if (r_czero || w_small) begin
                r_luma <= 8'd0;
            end else if (w_over) begin
                r_luma <= 8'd255;
            end
        end
        if (w_rsp.done) begin
            r_luma <= w_rsp.quotient;
        end
        if (w_load_out) begin
            r_ro <= heq_pkg::lin3(heq_pkg::K_RY, heq_pkg::K_RU, heq_pkg::K_RV,
                10'({2'b00, r_luma}) - heq_pkg::OFS_Y, 10'({2'b00, r_u}) - heq_pkg::OFS_C,
                10'({2'b00, r_v}) - heq_pkg::OFS_C, heq_pkg::OFS_0);
            r_go <= heq_pkg::lin3(heq_pkg::K_GY, heq_pkg::K_GU, heq_pkg::K_GV,
                10'({2'b00, r_luma}) - heq_pkg::OFS_Y, 10'({2'b00, r_u}) - heq_pkg::OFS_C,
                10'({2'b00, r_v}) - heq_pkg::OFS_C, heq_pkg::OFS_0);
            r_bo <= heq_pkg::lin3(heq_pkg::K_BY, heq_pkg::K_BU, heq_pkg::K_BV,
                10'({2'b00, r_luma}) - heq_pkg::OFS_Y, 10'({2'b00, r_u}) - heq_pkg::OFS_C,
                10'({2'b00, r_v}) - heq_pkg::OFS_C, heq_pkg::OFS_0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_ro;
    assign o_green_out = r_go;
    assign o_blue_out  = r_bo;

`ifndef SYNTHESIS
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bin_acc |=> r_ptr == $past(r_ptr) + LW'(1))
        else $error("bin pointer did not advance");
    a_wrap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bin_acc && r_ptr == LW'(heq_pkg::LEVELS - 1) |=> r_sum == '0)
        else $error("running sum not cleared at wrap");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == heq_pkg::ST_DIV)
        else $error("divider finished outside divide step");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == heq_pkg::ST_RGB)
        else $error("output raised without a finished pixel");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam logic OP_BIN   = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // One input item as the block sees it
    typedef struct {
        logic        op;
        logic [18:0] cnt;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } t_heq_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [heq_pkg::CFG_IDX_W-1:0] i_cfg_idx = heq_pkg::CFG_FRAME_WIDTH;
    logic [heq_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_operation = OP_BIN;
    logic [18:0] i_bin_count = '0;
    logic [7:0]  i_red_in = '0;
    logic [7:0]  i_green_in = '0;
    logic [7:0]  i_blue_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;

    rgb_luma_histogram_equalizer uut (.*);

    // Shadow state of the equalizer
    logic [heq_pkg::SUM_W-1:0] cdf_shadow [heq_pkg::LEVELS];
    logic [heq_pkg::SUM_W-1:0] sum_shadow;
    logic [7:0]                bin_ptr_shadow;
    logic [heq_pkg::CFG_W-1:0] width_shadow;
    logic [heq_pkg::CFG_W-1:0] height_shadow;

    t_heq_item   pending_items[$];
    logic [23:0] expected_pixels[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] clip8(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // Map luma through the shadow CDF table
    function automatic int remap_luma(input logic [7:0] y);
        longint unsigned w, h, area, c, q;
        w = (width_shadow > 1920) ? 1920 : width_shadow;
        h = (height_shadow > 1080) ? 1080 : height_shadow;
        area = w * h;
        c = cdf_shadow[y];
        if (c == 0 || area <= 1) return 0;
        q = ((c - 1) * 255) / (area - 1);
        if (q > 255) q = 255;
        return int'(q);
    endfunction

    function automatic logic [23:0] equalize_pixel(input logic [7:0] r8, g8, b8);
        int r, g, b, cy, du, ev;
        logic [7:0] yc, uc, vc;
        r = r8;
        g = g8;
        b = b8;
        yc = clip8(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        uc = clip8(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
        vc = clip8(((122 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
        cy = remap_luma(yc) - 16;
        du = int'(uc) - 128;
        ev = int'(vc) - 128;
        return {clip8((298 * cy + 409 * ev + 128) >>> 8),
                clip8((298 * cy - 100 * du - 208 * ev + 128) >>> 8),
                clip8((298 * cy + 516 * du + 128) >>> 8)};
    endfunction

    // Advance the shadow state for one accepted item
    task automatic absorb_item(input t_heq_item it);
        logic [heq_pkg::SUM_W:0] s;
        if (it.op == OP_BIN) begin
            s = sum_shadow + it.cnt;
            if (s > heq_pkg::SUM_MAX) s = heq_pkg::SUM_MAX;
            cdf_shadow[bin_ptr_shadow] = s[heq_pkg::SUM_W-1:0];
            if (bin_ptr_shadow == 8'd255) begin
                sum_shadow = '0;
            end else begin
                sum_shadow = s[heq_pkg::SUM_W-1:0];
            end
            bin_ptr_shadow = bin_ptr_shadow + 8'd1;
        end else begin
            expected_pixels.push_back(equalize_pixel(it.r, it.g, it.b));
        end
    endtask

    // Driver: hold each item until accepted, with random idle bursts
    int        in_gap = 0;
    t_heq_item cur_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) absorb_item(cur_item);
            if (!(i_in_valid && !o_in_ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    i_operation <= cur_item.op;
                    i_bin_count <= cur_item.cnt;
                    i_red_in    <= cur_item.r;
                    i_green_in  <= cur_item.g;
                    i_blue_in   <= cur_item.b;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the output in random bursts, check each item
    int          out_gap = 0;
    logic [23:0] want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel %h %h %h", $time,
                             o_red_out, o_green_out, o_blue_out);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want[23:16] !== o_red_out) begin
                        $display("%0t: red expected %0d actual %0d", $time,
                                 want[23:16], o_red_out);
                        mismatches++;
                    end
                    if (want[15:8] !== o_green_out) begin
                        $display("%0t: green expected %0d actual %0d", $time,
                                 want[15:8], o_green_out);
                        mismatches++;
                    end
                    if (want[7:0] !== o_blue_out) begin
                        $display("%0t: blue expected %0d actual %0d", $time,
                                 want[7:0], o_blue_out);
                        mismatches++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push_bin(input logic [18:0] cnt);
        t_heq_item it;
        it = '{OP_BIN, cnt, 8'($urandom), 8'($urandom), 8'($urandom)};
        pending_items.push_back(it);
    endtask

    task automatic push_pixel(input logic [7:0] r, g, b);
        t_heq_item it;
        it = '{OP_PIXEL, 19'($urandom), r, g, b};
        pending_items.push_back(it);
    endtask

    // Random count whose magnitude spans every bit width
    function automatic logic [18:0] random_count();
        int k;
        k = $urandom_range(0, 19);
        return (k == 19) ? 19'h7FFFF : 19'($urandom_range(0, (1 << k) - 1));
    endfunction

    // Drain everything, then give the pixel pipeline time to go quiet
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || i_in_valid || expected_pixels.size() != 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [heq_pkg::CFG_W-1:0] w, h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= heq_pkg::CFG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= heq_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        width_shadow  = w;
        height_shadow = h;
    endtask

    task automatic directed_pixels();
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd0, 8'd255);
        push_pixel(8'd128, 8'd128, 8'd128);
        push_pixel(8'd255, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd255);
    endtask

    initial begin
        int n;
        sum_shadow     = '0;
        bin_ptr_shadow = '0;
        width_shadow   = 11'd1920;
        height_shadow  = 11'd1080;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed load: empty dark bins give zero cdf, then saturate the sum
        for (int i = 0; i < heq_pkg::LEVELS; i++) begin
            if (i < 20) push_bin(19'd0);
            else if (i < 30) push_bin(19'h7FFFF);
            else push_bin(19'(i));
        end
        directed_pixels();
        drain();

        // Tiny, zero, oversized and two-pixel frames
        set_frame(11'd1, 11'd1);
        directed_pixels();
        drain();
        set_frame(11'd0, 11'd5);
        directed_pixels();
        drain();
        set_frame(11'd2047, 11'd2047);
        directed_pixels();
        drain();
        set_frame(11'd1, 11'd2);
        directed_pixels();
        drain();

        // Random phase: fresh histogram, then pixels mixed with a partial reload
        if ($urandom_range(0, 1)) begin
            set_frame(11'($urandom_range(1, 40)), 11'($urandom_range(1, 40)));
        end else begin
            set_frame(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
        end
        n = bin_ptr_shadow;
        for (int i = n; i < heq_pkg::LEVELS; i++) push_bin(($urandom_range(0, 3) == 0) ?
                                                  random_count() : 19'($urandom_range(0, 8)));
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 6) == 0) push_bin(random_count());
            else push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        drain();

        // Closing burst with no idling on either side
        quiet = 1'b1;
        for (int i = 0; i < 30; i++) push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        drain();

        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[rgb_luma_histogram_equalizer.f]
rtl/heq_pkg.sv
rtl/heq_cdf_ram.sv
rtl/heq_div.sv
rtl/rgb_luma_histogram_equalizer.sv
tb/tb_top.sv
